FILE: design/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mbdp_pkg.sv
// Types, constants and microcode table of the motion alert pulser.
package mbdp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int UPC_W      = 5;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DELTA_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BASELINE = 3'd4;

    localparam logic [14:0] RST_DELTA_THRESHOLD  = 15'd2458;
    localparam logic [9:0]  RST_PULSE_LENGTH_MS  = 10'd120;
    localparam logic [10:0] RST_PULSE_PERIOD_MS  = 11'd300;
    localparam logic [10:0] RST_CONTINUOUS_MS    = 11'd250;
    localparam logic [15:0] RST_INITIAL_BASELINE = 16'd16384;

    localparam logic [7:0]  TRIGGER_COUNT = 8'd3;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    // baseline average: divide by 1000, rounding offset 500
    localparam logic [37:0] AVG_ROUND   = 38'd500;
    localparam logic [37:0] AVG_CEIL    = 38'd999;
    localparam logic [11:0] DIV_K1      = 12'd1000;
    localparam logic [11:0] DIV_K2      = 12'd2000;
    localparam logic [11:0] DIV_K3      = 12'd3000;
    localparam logic [36:0] DEV_ROUND   = 37'h00_0008_0000;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_NOP,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT,
        OP_PREP1,
        OP_PREP2,
        OP_DIV,
        OP_BASE,
        OP_DEV1,
        OP_DEV2,
        OP_DEV3,
        OP_MOTION,
        OP_PEND,
        OP_REPEAT,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_NO_SAMPLE,
        C_LOOP,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             ld_cnt;
        logic [CNT_W-1:0] cnt;
    } t_ctrl;

    localparam logic [UPC_W-1:0] S_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] S_CHECK = 5'd1;
    localparam logic [UPC_W-1:0] S_SQ_X  = 5'd2;
    localparam logic [UPC_W-1:0] S_SQ_Y  = 5'd3;
    localparam logic [UPC_W-1:0] S_SQ_Z  = 5'd4;
    localparam logic [UPC_W-1:0] S_SQRT  = 5'd5;
    localparam logic [UPC_W-1:0] S_PREP1 = 5'd6;
    localparam logic [UPC_W-1:0] S_PREP2 = 5'd7;
    localparam logic [UPC_W-1:0] S_DIV   = 5'd8;
    localparam logic [UPC_W-1:0] S_BASE  = 5'd9;
    localparam logic [UPC_W-1:0] S_DEV1  = 5'd10;
    localparam logic [UPC_W-1:0] S_DEV2  = 5'd11;
    localparam logic [UPC_W-1:0] S_DEV3  = 5'd12;
    localparam logic [UPC_W-1:0] S_MOT   = 5'd13;
    localparam logic [UPC_W-1:0] S_PEND  = 5'd14;
    localparam logic [UPC_W-1:0] S_REP   = 5'd15;
    localparam logic [UPC_W-1:0] S_OUT   = 5'd16;
    localparam logic [UPC_W-1:0] S_BACK  = 5'd17;

    localparam logic [CNT_W-1:0] SQRT_LOOPS = 4'd15;
    localparam logic [CNT_W-1:0] DIV_LOOPS  = 4'd13;

    function automatic t_ctrl ucode(input logic [UPC_W-1:0] step);
        t_ctrl w;
        w.op     = OP_NOP;
        w.cond   = C_NEXT;
        w.target = S_IDLE;
        w.ld_cnt = 1'b0;
        w.cnt    = '0;
        case (step)
            S_IDLE: begin
                w.op     = OP_IDLE;
                w.cond   = C_NO_ACCEPT;
                w.target = S_IDLE;
            end
            S_CHECK: begin
                w.cond   = C_NO_SAMPLE;
                w.target = S_PEND;
            end
            S_SQ_X: w.op = OP_SQ_X;
            S_SQ_Y: w.op = OP_SQ_Y;
            S_SQ_Z: begin
                w.op     = OP_SQ_Z;
                w.ld_cnt = 1'b1;
                w.cnt    = SQRT_LOOPS;
            end
            S_SQRT: begin
                w.op     = OP_SQRT;
                w.cond   = C_LOOP;
                w.target = S_SQRT;
            end
            S_PREP1: w.op = OP_PREP1;
            S_PREP2: begin
                w.op     = OP_PREP2;
                w.ld_cnt = 1'b1;
                w.cnt    = DIV_LOOPS;
            end
            S_DIV: begin
                w.op     = OP_DIV;
                w.cond   = C_LOOP;
                w.target = S_DIV;
            end
            S_BASE: w.op = OP_BASE;
            S_DEV1: w.op = OP_DEV1;
            S_DEV2: w.op = OP_DEV2;
            S_DEV3: w.op = OP_DEV3;
            S_MOT:  w.op = OP_MOTION;
            S_PEND: w.op = OP_PEND;
            S_REP:  w.op = OP_REPEAT;
            S_OUT: begin
                w.op     = OP_OUT;
                w.cond   = C_OUT_BUSY;
                w.target = S_OUT;
            end
            S_BACK: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [15:0] abs16(input logic [15:0] v);
        return v[15] ? 16'(~v + 16'd1) : v;
    endfunction

endpackage

FILE: design/motion_bite_detector_pulser.sv
// Motion alert pulser: microcoded sequencer over a sqrt/divide datapath.
// Item with a sample: squares, sqrt, divide, baseline, deviation, motion, pulse, output.
// Item without a sample: pulse and output steps only. No accept until back in idle.
// Sampled-item time is set by the 16-step square root and the 14-step radix-4 divide.
// Synchronous active-low reset loads register defaults and the baseline from them.
`include "assert_macros.svh"

module motion_bite_detector_pulser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_now_ms,
    input  logic                              i_sample_valid,
    input  logic signed [15:0]                i_accel_x,
    input  logic signed [15:0]                i_accel_y,
    input  logic signed [15:0]                i_accel_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_pulse_active,
    output logic                              o_pulse_started,
    output logic                              o_motion_flag,
    output logic [15:0]                       o_last_deviation,
    output logic [31:0]                       o_alerts_total,
    input  logic                              i_cfg_we,
    input  logic [mbdp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbdp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mbdp_pkg::*;

    t_ctrl              ctrl;

    logic [UPC_W-1:0]   r_upc, n_upc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [14:0]        r_thr, n_thr;
    logic [9:0]         r_len, n_len;
    logic [10:0]        r_period, n_period;
    logic [10:0]        r_cont, n_cont;
    logic [15:0]        r_init, n_init;

    logic [35:0]        r_acc, n_acc;
    logic [7:0]         r_count, n_count;
    logic               r_moving, n_moving;
    logic [31:0]        r_mst, n_mst;
    logic               r_pon, n_pon;
    logic [31:0]        r_pet, n_pet;
    logic [31:0]        r_pst, n_pst;
    logic [31:0]        r_alerts, n_alerts;
    logic [15:0]        r_devh, n_devh;
    logic               r_started, n_started;

    logic               r_ovalid, n_ovalid;
    logic               r_o_pon, n_o_pon;
    logic               r_o_started, n_o_started;
    logic               r_o_moving, n_o_moving;
    logic [15:0]        r_o_dev, n_o_dev;
    logic [31:0]        r_o_alerts, n_o_alerts;

    logic [31:0]        r_now, n_now;
    logic               r_sv, n_sv;
    logic [15:0]        r_x, n_x;
    logic [15:0]        r_y, n_y;
    logic [15:0]        r_z, n_z;
    logic [31:0]        r_sum, n_sum;
    logic [17:0]        r_rem, n_rem;
    logic [15:0]        r_root, n_root;
    logic [37:0]        r_t, n_t;
    logic               r_neg, n_neg;
    logic [9:0]         r_drem, n_drem;
    logic [27:0]        r_dsh, n_dsh;
    logic [27:0]        r_q, n_q;
    logic [35:0]        r_d, n_d;

    logic [15:0]        mul_a;
    logic [31:0]        sq;
    logic [19:0]        sqrt_cand, sqrt_trial;
    logic [11:0]        div_r12;
    logic [1:0]         div_digit;
    logic [11:0]        div_sub;
    logic [35:0]        m20;
    logic [37:0]        prep_u;
    logic [36:0]        dev_rnd;
    logic               do_begin;
    logic               motion_now;

    assign ctrl    = ucode(r_upc);
    assign o_stall = (ctrl.op != OP_IDLE);
    assign m20     = {r_root, 20'b0};

    always_comb begin
        case (ctrl.op)
            OP_SQ_X: mul_a = abs16(r_x);
            OP_SQ_Y: mul_a = abs16(r_y);
            default: mul_a = abs16(r_z);
        endcase
    end
    assign sq = 32'(mul_a) * 32'(mul_a);

    assign sqrt_cand  = {r_rem, r_sum[31:30]};
    assign sqrt_trial = {2'b00, r_root, 2'b01};

    assign div_r12 = {r_drem, r_dsh[27:26]};
    always_comb begin
        if (div_r12 >= DIV_K3) begin
            div_digit = 2'd3;
            div_sub   = DIV_K3;
        end else if (div_r12 >= DIV_K2) begin
            div_digit = 2'd2;
            div_sub   = DIV_K2;
        end else if (div_r12 >= DIV_K1) begin
            div_digit = 2'd1;
            div_sub   = DIV_K1;
        end else begin
            div_digit = 2'd0;
            div_sub   = 12'd0;
        end
    end

    assign prep_u     = r_t[37] ? (AVG_CEIL - r_t) : r_t;
    assign dev_rnd    = {1'b0, r_d} + DEV_ROUND;
    assign motion_now = (r_count >= TRIGGER_COUNT);

    always_comb begin
        n_upc       = r_upc + 5'd1;
        n_cnt       = r_cnt;
        n_thr       = r_thr;
        n_len       = r_len;
        n_period    = r_period;
        n_cont      = r_cont;
        n_init      = r_init;
        n_acc       = r_acc;
        n_count     = r_count;
        n_moving    = r_moving;
        n_mst       = r_mst;
        n_pon       = r_pon;
        n_pet       = r_pet;
        n_pst       = r_pst;
        n_alerts    = r_alerts;
        n_devh      = r_devh;
        n_started   = r_started;
        n_ovalid    = r_ovalid && i_stall;
        n_o_pon     = r_o_pon;
        n_o_started = r_o_started;
        n_o_moving  = r_o_moving;
        n_o_dev     = r_o_dev;
        n_o_alerts  = r_o_alerts;
        n_now       = r_now;
        n_sv        = r_sv;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_root      = r_root;
        n_t         = r_t;
        n_neg       = r_neg;
        n_drem      = r_drem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_d         = r_d;
        do_begin    = 1'b0;

        case (ctrl.cond)
            C_NEXT:      n_upc = r_upc + 5'd1;
            C_ALWAYS:    n_upc = ctrl.target;
            C_NO_ACCEPT: if (!i_valid) n_upc = ctrl.target;
            C_NO_SAMPLE: if (!r_sv) n_upc = ctrl.target;
            C_LOOP:      if (r_cnt != '0) n_upc = ctrl.target;
            C_OUT_BUSY:  if (r_ovalid && i_stall) n_upc = ctrl.target;
            default:     n_upc = S_IDLE;
        endcase
        if (ctrl.ld_cnt) begin
            n_cnt = ctrl.cnt;
        end else if (ctrl.cond == C_LOOP) begin
            n_cnt = r_cnt - 4'd1;
        end

        case (ctrl.op)
            OP_IDLE: begin
                if (i_valid) begin
                    n_now     = i_now_ms;
                    n_sv      = i_sample_valid;
                    n_x       = i_accel_x;
                    n_y       = i_accel_y;
                    n_z       = i_accel_z;
                    n_started = 1'b0;
                end
            end
            OP_SQ_X: begin
                n_sum  = sq;
                n_rem  = '0;
                n_root = '0;
            end
            OP_SQ_Y, OP_SQ_Z: n_sum = r_sum + sq;
            OP_SQRT: begin
                n_sum = {r_sum[29:0], 2'b00};
                if (sqrt_cand >= sqrt_trial) begin
                    n_rem  = 18'(sqrt_cand - sqrt_trial);
                    n_root = {r_root[14:0], 1'b1};
                end else begin
                    n_rem  = sqrt_cand[17:0];
                    n_root = {r_root[14:0], 1'b0};
                end
            end
            OP_PREP1: n_t = {2'b00, m20} - {2'b00, r_acc} + AVG_ROUND;
            OP_PREP2: begin
                n_neg  = r_t[37];
                n_drem = {1'b0, prep_u[36:28]};
                n_dsh  = prep_u[27:0];
                n_q    = '0;
            end
            OP_DIV: begin
                n_drem = 10'(div_r12 - div_sub);
                n_dsh  = {r_dsh[25:0], 2'b00};
                n_q    = {r_q[25:0], div_digit};
            end
            OP_BASE: n_acc = r_neg ? (r_acc - {8'b0, r_q}) : (r_acc + {8'b0, r_q});
            OP_DEV1: n_t = {2'b00, m20} - {2'b00, r_acc};
            OP_DEV2: n_d = r_t[37] ? 36'(38'd0 - r_t) : r_t[35:0];
            OP_DEV3: begin
                n_devh = dev_rnd[36] ? 16'hFFFF : dev_rnd[35:20];
                if (r_d >= {1'b0, r_thr, 20'b0}) begin
                    if (r_count != COUNT_MAX) n_count = r_count + 8'd1;
                end else if (r_count != 8'd0) begin
                    n_count = r_count - 8'd1;
                end
            end
            OP_MOTION: begin
                if (motion_now && !r_moving) begin
                    n_moving = 1'b1;
                    n_mst    = r_now;
                    do_begin = 1'b1;
                end else if (!motion_now && r_moving) begin
                    n_moving = 1'b0;
                end
            end
            OP_PEND: begin
                if (r_pon && !n_pet_diff_msb(r_now, r_pet)) n_pon = 1'b0;
            end
            OP_REPEAT: begin
                if (r_moving && ((r_now - r_mst) >= {21'b0, r_cont}) && !r_pon
                        && ((r_now - r_pst) >= {21'b0, r_period})) begin
                    do_begin = 1'b1;
                end
            end
            OP_OUT: begin
                if (!(r_ovalid && i_stall)) begin
                    n_ovalid    = 1'b1;
                    n_o_pon     = r_pon;
                    n_o_started = r_started;
                    n_o_moving  = r_moving;
                    n_o_dev     = r_devh;
                    n_o_alerts  = r_alerts;
                end
            end
            default: ;
        endcase

        if (do_begin) begin
            n_pon     = 1'b1;
            n_pst     = r_now;
            n_pet     = r_now + {22'b0, r_len};
            n_alerts  = r_alerts + 32'd1;
            n_started = 1'b1;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DELTA_THRESHOLD: n_thr    = i_cfg_data[14:0];
                REG_PULSE_LENGTH_MS: n_len    = i_cfg_data[9:0];
                REG_PULSE_PERIOD_MS: n_period = i_cfg_data[10:0];
                REG_CONTINUOUS_MS:   n_cont   = i_cfg_data[10:0];
                REG_INITIAL_BASELINE: begin
                    n_init = i_cfg_data;
                    n_acc  = {i_cfg_data, 20'b0};
                end
                default: ;
            endcase
        end
    end

    // sign of the wrapped time difference now - end
    function automatic logic n_pet_diff_msb(input logic [31:0] now, input logic [31:0] pet);
        logic [31:0] diff;
        diff = now - pet;
        return diff[31];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= S_IDLE;
            r_cnt     <= '0;
            r_thr     <= RST_DELTA_THRESHOLD;
            r_len     <= RST_PULSE_LENGTH_MS;
            r_period  <= RST_PULSE_PERIOD_MS;
            r_cont    <= RST_CONTINUOUS_MS;
            r_init    <= RST_INITIAL_BASELINE;
            r_acc     <= {RST_INITIAL_BASELINE, 20'b0};
            r_count   <= '0;
            r_moving  <= 1'b0;
            r_mst     <= '0;
            r_pon     <= 1'b0;
            r_pet     <= '0;
            r_pst     <= '0;
            r_alerts  <= '0;
            r_devh    <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_upc     <= n_upc;
            r_cnt     <= n_cnt;
            r_thr     <= n_thr;
            r_len     <= n_len;
            r_period  <= n_period;
            r_cont    <= n_cont;
            r_init    <= n_init;
            r_acc     <= n_acc;
            r_count   <= n_count;
            r_moving  <= n_moving;
            r_mst     <= n_mst;
            r_pon     <= n_pon;
            r_pet     <= n_pet;
            r_pst     <= n_pst;
            r_alerts  <= n_alerts;
            r_devh    <= n_devh;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_pon     <= n_o_pon;
        r_o_started <= n_o_started;
        r_o_moving  <= n_o_moving;
        r_o_dev     <= n_o_dev;
        r_o_alerts  <= n_o_alerts;
        r_now       <= n_now;
        r_sv        <= n_sv;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_t         <= n_t;
        r_neg       <= n_neg;
        r_drem      <= n_drem;
        r_dsh       <= n_dsh;
        r_q         <= n_q;
        r_d         <= n_d;
    end

    assign o_valid          = r_ovalid;
    assign o_pulse_active   = r_o_pon;
    assign o_pulse_started  = r_o_started;
    assign o_motion_flag    = r_o_moving;
    assign o_last_deviation = r_o_dev;
    assign o_alerts_total   = r_o_alerts;

    `ASSERT_NEXT(a_accept_to_check, i_valid && !o_stall, r_upc == S_CHECK, "accept did not advance")
    `ASSERT_NOW(a_count_step, 1'b1, r_count == $past(r_count) || r_count == $past(r_count) + 8'd1 || r_count == $past(r_count) - 8'd1, "trigger count jumped")
    `ASSERT_NOW(a_onset_alert, $rose(r_moving), r_alerts == $past(r_alerts) + 32'd1, "onset without pulse")

endmodule
